// ===== rtl/utf8d_pkg.sv =====
// ============================================================================
// utf8d_pkg
// Shared constants for the UTF-8 to code point decoder.
// ============================================================================
package utf8d_pkg;

    // Field widths.
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CodeW  = 31;
    localparam int unsigned CountW = 3;

    // Byte class boundaries of the legacy six-byte form.
    localparam logic [ByteW-1:0] ContLow   = 8'h80;
    localparam logic [ByteW-1:0] ContHigh  = 8'hBF;
    localparam logic [ByteW-1:0] Lead2Low  = 8'hC0;
    localparam logic [ByteW-1:0] Lead3Low  = 8'hE0;
    localparam logic [ByteW-1:0] Lead4Low  = 8'hF0;
    localparam logic [ByteW-1:0] Lead5Low  = 8'hF8;
    localparam logic [ByteW-1:0] Lead6Low  = 8'hFC;
    localparam logic [ByteW-1:0] LeadHigh  = 8'hFD;

    // Payload bits carried by every continuation byte.
    localparam logic [ByteW-1:0] ContMask  = 8'h3F;

    // Value given for a stray lead byte.
    localparam logic [CodeW-1:0] Replacement = 31'h0000_FFFD;

endpackage

// ===== rtl/utf8_to_codepoint_decoder_unit.sv =====
// ============================================================================
// utf8_to_codepoint_decoder_unit
// Decodes one UTF-8 byte per transfer into code points (legacy 1 to 6 byte
// form), with a replacement value for stray lead bytes and one error result
// for a broken or truncated sequence.
// ============================================================================
//
//  Channel   Direction  Payload                                      Handshake
//  s_        in         s_data_byte[7:0], s_last_byte                s_valid/s_ready
//  m_        out        m_code_point[30:0], m_bad_sequence,          m_valid/m_ready
//                       m_last_result
//
// One byte is taken per cycle while the result side does not stall. A byte
// passes an input register and is decoded from it into the result register,
// which presents its result. Bytes that complete no character give no
// result.
// The decoder state (partial value, continuation count, drop flag) is updated
// only when the input register hands its byte on. Reset is synchronous and
// active low and clears both registers' valid flags and the decoder state.
// A stall on the result side holds the result register and then the input
// register; nothing is lost or repeated.
module utf8_to_codepoint_decoder_unit
    import utf8d_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ByteW-1:0] s_data_byte,
    input  logic             s_last_byte,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [CodeW-1:0] m_code_point,
    output logic             m_bad_sequence,
    output logic             m_last_result
);

    // Input register.
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_last_reg;

    // Decoder state.
    logic [CodeW-1:0]  partial_reg, partial_next;
    logic [CountW-1:0] left_reg, left_next;
    logic              drop_reg, drop_next;

    // Result register.
    logic             out_valid_reg;
    logic [CodeW-1:0] out_code_reg, out_code_next;
    logic             out_bad_reg, out_bad_next;
    logic             out_last_reg;
    logic             emit_next;

    logic              advance;
    logic              is_cont;
    logic [CodeW-1:0]  shifted;
    logic [CountW-1:0] left_dec;

    // The input byte moves on when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign is_cont  = (in_byte_reg >= ContLow) && (in_byte_reg <= ContHigh);
    assign shifted  = {partial_reg[CodeW-7:0], in_byte_reg[5:0] & ContMask[5:0]};
    assign left_dec = left_reg - CountW'(1);

    // Decode one byte against the current sequence state.
    always_comb begin
        partial_next  = partial_reg;
        left_next     = left_reg;
        drop_next     = drop_reg;
        emit_next     = 1'b0;
        out_code_next = '0;
        out_bad_next  = 1'b0;

        if (drop_reg) begin
            // Rest of a failed string is dropped up to its last byte.
            if (in_last_reg) begin
                drop_next    = 1'b0;
                partial_next = '0;
                left_next    = '0;
            end
        end else if (left_reg != '0) begin
            if (!is_cont) begin
                emit_next    = 1'b1;
                out_bad_next = 1'b1;
                partial_next = '0;
                left_next    = '0;
                drop_next    = !in_last_reg;
            end else if (left_dec == '0) begin
                emit_next     = 1'b1;
                out_code_next = shifted;
                partial_next  = '0;
                left_next     = '0;
            end else if (in_last_reg) begin
                // String ends inside the sequence.
                emit_next    = 1'b1;
                out_bad_next = 1'b1;
                partial_next = '0;
                left_next    = '0;
            end else begin
                partial_next = shifted;
                left_next    = left_dec;
            end
        end else if (in_byte_reg < ContLow) begin
            emit_next     = 1'b1;
            out_code_next = {{(CodeW-ByteW){1'b0}}, in_byte_reg};
        end else if ((in_byte_reg < Lead2Low) || (in_byte_reg > LeadHigh)) begin
            emit_next     = 1'b1;
            out_code_next = Replacement;
        end else begin
            // Lead byte: keep its payload bits and the continuation count.
            if (in_byte_reg < Lead3Low) begin
                partial_next = {{(CodeW-5){1'b0}}, in_byte_reg[4:0]};
                left_next    = CountW'(1);
            end else if (in_byte_reg < Lead4Low) begin
                partial_next = {{(CodeW-4){1'b0}}, in_byte_reg[3:0]};
                left_next    = CountW'(2);
            end else if (in_byte_reg < Lead5Low) begin
                partial_next = {{(CodeW-3){1'b0}}, in_byte_reg[2:0]};
                left_next    = CountW'(3);
            end else if (in_byte_reg < Lead6Low) begin
                partial_next = {{(CodeW-2){1'b0}}, in_byte_reg[1:0]};
                left_next    = CountW'(4);
            end else begin
                partial_next = {{(CodeW-1){1'b0}}, in_byte_reg[0]};
                left_next    = CountW'(5);
            end
            if (in_last_reg) begin
                emit_next    = 1'b1;
                out_bad_next = 1'b1;
                partial_next = '0;
                left_next    = '0;
            end
        end
    end

    // Input register and decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            partial_reg  <= '0;
            left_reg     <= '0;
            drop_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                partial_reg <= partial_next;
                left_reg    <= left_next;
                drop_reg    <= drop_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= advance && emit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit_next) begin
            out_code_reg <= out_code_next;
            out_bad_reg  <= out_bad_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_code_point   = out_code_reg;
    assign m_bad_sequence = out_bad_reg;
    assign m_last_result  = out_last_reg;

endmodule

// ===== rtl/utf8d_checker.sv =====
// ============================================================================
// utf8d_checker
// Port-level checks for the UTF-8 decoder, bound to its top level.
// ============================================================================
module utf8d_checker
    import utf8d_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [ByteW-1:0] s_data_byte,
    input logic             s_last_byte,
    input logic             m_valid,
    input logic             m_ready,
    input logic [CodeW-1:0] m_code_point,
    input logic             m_bad_sequence,
    input logic             m_last_result
);

    // A stalled result holds until its transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point)
            && $stable(m_bad_sequence) && $stable(m_last_result))
        else $error("result changed while stalled");

    // An error result carries no code point.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_sequence |-> m_code_point == '0)
        else $error("error result with nonzero code point");

    // No result directly after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The input side is open whenever no result is waiting.
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty result register");

    // An offered byte holds until its transfer.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data_byte) && $stable(s_last_byte))
        else $error("input byte changed while stalled");

endmodule

bind utf8_to_codepoint_decoder_unit utf8d_checker u_utf8d_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_data_byte    (s_data_byte),
    .s_last_byte    (s_last_byte),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_code_point   (m_code_point),
    .m_bad_sequence (m_bad_sequence),
    .m_last_result  (m_last_result)
);

// ===== sim/tb_utf8_to_codepoint_decoder_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_utf8_to_codepoint_decoder_unit
// Self-checking bench for the UTF-8 to code point decoder. A short directed
// table covers the byte classes, the widest six-byte sequence, truncation,
// broken continuations and the dropping of a failed string's tail. Random
// strings follow, mostly well formed with random content and some noise.
// Each accepted byte is run through a local decoder model, and each result
// transfer is compared against the oldest expected result. The sender and
// the receiver idle at different rates over the phases, and one long
// receiver hold-off backs the block up into its input.
// ============================================================================
module tb_utf8_to_codepoint_decoder_unit;
    import utf8d_pkg::*;

    localparam int unsigned HoldCycles = 60;
    localparam int unsigned PhaseItems = 240;
    localparam int unsigned NumPhases  = 4;
    localparam int unsigned IdlePct [NumPhases] = '{0, 49, 0, 11};
    localparam int unsigned StallPct[NumPhases] = '{0, 0, 49, 11};

    // Where a row's expected result comes from.
    typedef enum logic [1:0] {
        SRC_MODEL,
        SRC_NONE,
        SRC_TYPED
    } exp_src_t;

    typedef struct packed {
        logic [CodeW-1:0] code_point;
        logic             bad_sequence;
        logic             last_result;
    } cp_result_t;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             last_byte;
        exp_src_t         src;
        cp_result_t       res;
    } stim_row_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [ByteW-1:0] s_data_byte;
    logic             s_last_byte;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [CodeW-1:0] m_code_point;
    logic             m_bad_sequence;
    logic             m_last_result;

    // Local copy of the decoder state.
    logic [CodeW-1:0]  acc_value = '0;
    logic [CountW-1:0] cont_left = '0;
    logic              dropping  = 1'b0;

    cp_result_t  expected_cp_q[$];
    stim_row_t   offered_q[$];

    int unsigned fail_cnt     = 0;
    int unsigned decoded_cnt  = 0;
    int unsigned string_cnt   = 0;
    int unsigned checked_cnt  = 0;
    int unsigned bad_seq_cnt  = 0;
    int unsigned replaced_cnt = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    logic        hold_req;
    logic        hold_done = 1'b0;
    int unsigned hold_cnt  = 0;

    // Directed table: byte classes, extremes, truncation and broken strings.
    stim_row_t dir_rows [24] = '{
        '{8'h00, 1'b1, SRC_TYPED, '{31'h0000_0000, 1'b0, 1'b1}},
        '{8'h7F, 1'b1, SRC_TYPED, '{31'h0000_007F, 1'b0, 1'b1}},
        '{8'h80, 1'b0, SRC_TYPED, '{31'h0000_FFFD, 1'b0, 1'b0}},
        '{8'hBF, 1'b1, SRC_TYPED, '{31'h0000_FFFD, 1'b0, 1'b1}},
        '{8'hFE, 1'b0, SRC_TYPED, '{31'h0000_FFFD, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, SRC_TYPED, '{31'h0000_FFFD, 1'b0, 1'b1}},
        // Two-byte character.
        '{8'hC2, 1'b0, SRC_NONE,  '0},
        '{8'hA9, 1'b1, SRC_MODEL, '0},
        // Widest six-byte sequence gives the largest value.
        '{8'hFD, 1'b0, SRC_NONE,  '0},
        '{8'hBF, 1'b0, SRC_NONE,  '0},
        '{8'hBF, 1'b0, SRC_NONE,  '0},
        '{8'hBF, 1'b0, SRC_NONE,  '0},
        '{8'hBF, 1'b0, SRC_NONE,  '0},
        '{8'hBF, 1'b1, SRC_TYPED, '{31'h7FFF_FFFF, 1'b0, 1'b1}},
        // String that ends on a lead byte.
        '{8'hE0, 1'b1, SRC_TYPED, '{31'h0000_0000, 1'b1, 1'b1}},
        // String that ends on a valid continuation byte.
        '{8'hF0, 1'b0, SRC_NONE,  '0},
        '{8'h90, 1'b1, SRC_TYPED, '{31'h0000_0000, 1'b1, 1'b1}},
        // Bad continuation mid-string, then the rest of the string is dropped.
        '{8'hE1, 1'b0, SRC_NONE,  '0},
        '{8'h41, 1'b0, SRC_TYPED, '{31'h0000_0000, 1'b1, 1'b0}},
        '{8'h42, 1'b0, SRC_NONE,  '0},
        '{8'h43, 1'b1, SRC_NONE,  '0},
        '{8'h41, 1'b1, SRC_MODEL, '0},
        // Bad continuation on the string's last byte.
        '{8'hC3, 1'b0, SRC_NONE,  '0},
        '{8'hC3, 1'b1, SRC_TYPED, '{31'h0000_0000, 1'b1, 1'b1}}
    };

    utf8_to_codepoint_decoder_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_point   (m_code_point),
        .m_bad_sequence (m_bad_sequence),
        .m_last_result  (m_last_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Decodes one byte against the local state; returns 1 when a result is due.
    function automatic logic decode_byte(input logic [ByteW-1:0] b, input logic lst,
                                         output cp_result_t r);
        r = '0;
        if (dropping) begin
            if (lst) begin
                acc_value = '0;
                cont_left = '0;
                dropping  = 1'b0;
            end
            return 1'b0;
        end
        if (cont_left != 0) begin
            if (b < ContLow || b > ContHigh) begin
                r         = '{'0, 1'b1, lst};
                acc_value = '0;
                cont_left = '0;
                dropping  = !lst;
                return 1'b1;
            end
            acc_value = {acc_value[CodeW-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0) begin
                r         = '{acc_value, 1'b0, lst};
                acc_value = '0;
                return 1'b1;
            end
            if (lst) begin
                r         = '{'0, 1'b1, 1'b1};
                acc_value = '0;
                cont_left = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (b < ContLow) begin
            r = '{{{(CodeW-ByteW){1'b0}}, b}, 1'b0, lst};
            return 1'b1;
        end
        if (b < Lead2Low || b > LeadHigh) begin
            r = '{Replacement, 1'b0, lst};
            return 1'b1;
        end

        // Lead byte: keep its payload bits and the number of bytes to follow.
        acc_value = '0;
        if (b < Lead3Low) begin
            acc_value[4:0] = b[4:0];
            cont_left      = 3'd1;
        end else if (b < Lead4Low) begin
            acc_value[3:0] = b[3:0];
            cont_left      = 3'd2;
        end else if (b < Lead5Low) begin
            acc_value[2:0] = b[2:0];
            cont_left      = 3'd3;
        end else if (b < Lead6Low) begin
            acc_value[1:0] = b[1:0];
            cont_left      = 3'd4;
        end else begin
            acc_value[0]   = b[0];
            cont_left      = 3'd5;
        end
        if (lst) begin
            r         = '{'0, 1'b1, 1'b1};
            acc_value = '0;
            cont_left = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Sequence length of a random character, mostly short ones.
    function automatic int unsigned rand_seq_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3);
    endfunction

    function automatic logic [ByteW-1:0] lead_byte(input int unsigned n);
        case (n)
            2:       return {3'b110, 5'($urandom())};
            3:       return {4'b1110, 4'($urandom())};
            4:       return {5'b11110, 3'($urandom())};
            5:       return {6'b111110, 2'($urandom())};
            default: return {7'b1111110, 1'($urandom())};
        endcase
    endfunction

    function automatic logic [ByteW-1:0] cont_byte();
        return {2'b10, 6'($urandom())};
    endfunction

    // Offers one byte and returns at the edge where it is transferred.
    task automatic send_byte(input stim_row_t row);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= row.data_byte;
        s_last_byte <= row.last_byte;
        offered_q.push_back(row);
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
    endtask

    // Builds one random string and sends it byte by byte.
    task automatic gen_string();
        logic [ByteW-1:0] seq[$];
        stim_row_t        row;
        int unsigned      nch;
        int unsigned      kind;
        int unsigned      len;
        int unsigned      v;
        if ($urandom_range(0, 99) < 10) begin
            // Noise: any byte values at all.
            nch = $urandom_range(1, 8);
            repeat (nch) seq.push_back(8'($urandom()));
        end else begin
            nch = $urandom_range(1, 6);
            repeat (nch) begin
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    seq.push_back(8'($urandom_range(0, 127)));
                end else if (kind < 85) begin
                    len = rand_seq_len();
                    seq.push_back(lead_byte(len));
                    repeat (len - 1) seq.push_back(cont_byte());
                end else if (kind < 92) begin
                    // Stray lead byte: a lone continuation, 0xFE or 0xFF.
                    v = $urandom_range(0, 65);
                    seq.push_back(v < 64 ? 8'(8'h80 + v) : (v == 64 ? 8'hFE : 8'hFF));
                end else begin
                    // Sequence broken by a byte that is no continuation.
                    len = rand_seq_len();
                    seq.push_back(lead_byte(len));
                    repeat ($urandom_range(0, len - 2)) seq.push_back(cont_byte());
                    v = $urandom_range(0, 191);
                    seq.push_back(v < 128 ? 8'(v) : 8'(v + 64));
                end
            end
            // Now and then the string stops inside a sequence.
            if ($urandom_range(0, 99) < 8) begin
                len = rand_seq_len();
                seq.push_back(lead_byte(len));
                repeat ($urandom_range(0, len - 2)) seq.push_back(cont_byte());
            end
        end
        string_cnt++;
        for (int i = 0; i < seq.size(); i++) begin
            row           = '0;
            row.data_byte = seq[i];
            row.last_byte = (i == seq.size() - 1);
            row.src       = SRC_MODEL;
            send_byte(row);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= HoldCycles;
            m_ready   <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready  <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Scoreboard: check result transfers, then predict from byte transfers.
    always @(posedge aclk) begin : scoreboard
        cp_result_t want;
        cp_result_t pred;
        stim_row_t  row;
        logic       has_res;
        logic       was_dropping;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_cp_q.size() == 0) begin
                    $error("unexpected result: code_point %h bad_sequence %b last_result %b",
                           m_code_point, m_bad_sequence, m_last_result);
                    fail_cnt++;
                end else begin
                    want = expected_cp_q.pop_front();
                    checked_cnt++;
                    if (m_code_point !== want.code_point) begin
                        $error("code_point: expected %h, got %h", want.code_point, m_code_point);
                        fail_cnt++;
                    end
                    if (m_bad_sequence !== want.bad_sequence) begin
                        $error("bad_sequence: expected %b, got %b",
                               want.bad_sequence, m_bad_sequence);
                        fail_cnt++;
                    end
                    if (m_last_result !== want.last_result) begin
                        $error("last_result: expected %b, got %b",
                               want.last_result, m_last_result);
                        fail_cnt++;
                    end
                    if (want.bad_sequence) bad_seq_cnt++;
                    if (want.code_point == Replacement && !want.bad_sequence) replaced_cnt++;
                end
            end
            if (s_valid && s_ready) begin
                row          = offered_q.pop_front();
                was_dropping = dropping;
                has_res      = decode_byte(s_data_byte, s_last_byte, pred);
                if (!was_dropping) decoded_cnt++;
                case (row.src)
                    SRC_MODEL: if (has_res) expected_cp_q.push_back(pred);
                    SRC_TYPED: expected_cp_q.push_back(row.res);
                    default:   ;
                endcase
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin : stimulus
        int unsigned phase_end;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_last_byte = 1'b0;
        hold_req    = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_byte(dir_rows[i]);

        for (int p = 0; p < NumPhases; p++) begin
            send_idle_pct = IdlePct[p];
            stall_pct     = StallPct[p];
            // Back the block up while the sender keeps offering bytes.
            if (p == 0) hold_req <= 1'b1;
            phase_end = decoded_cnt + PhaseItems;
            while (decoded_cnt < phase_end) gen_string();
        end
        s_valid <= 1'b0;

        for (int w = 0; w < 4000 && expected_cp_q.size() != 0; w++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_cp_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_cp_q.size());
            fail_cnt += expected_cp_q.size();
        end

        $display("Sent %0d random strings plus the directed table; %0d bytes decoded.",
                 string_cnt, decoded_cnt);
        $display("Checked %0d results: %0d error results, %0d replacement characters.",
                 checked_cnt, bad_seq_cnt, replaced_cnt);
        if (fail_cnt == 0) begin
            $display("tb_utf8_to_codepoint_decoder_unit: PASS");
        end else begin
            $display("tb_utf8_to_codepoint_decoder_unit: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("tb_utf8_to_codepoint_decoder_unit: FAIL");
        $finish;
    end

endmodule
